// ===== rtl/ppre_pkg.sv =====
// ----------------------------------------------------------------------------
// ppre_pkg
// Shared types and constants of the Pauli product rotation engine.
// ----------------------------------------------------------------------------
package ppre_pkg;

  localparam int QUBITS_DEF = 10;
  localparam int MASK_W     = 10;
  localparam int IDX_W      = 10;
  localparam int AMP_W      = 16;
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 4;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

  localparam logic [CMD_W-1:0] KIND_WACK = 2'd0;
  localparam logic [CMD_W-1:0] KIND_RDAT = 2'd1;
  localparam logic [CMD_W-1:0] KIND_DONE = 2'd2;

  localparam logic [ADDR_W-1:0] REG_FLIP  = 4'h0;
  localparam logic [ADDR_W-1:0] REG_PHASE = 4'h4;
  localparam logic [ADDR_W-1:0] REG_COS   = 4'h8;
  localparam logic [ADDR_W-1:0] REG_SIN   = 4'hC;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        index;
    logic signed [AMP_W-1:0] in_re;
    logic signed [AMP_W-1:0] in_im;
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]        kind;
    logic signed [AMP_W-1:0] out_re;
    logic signed [AMP_W-1:0] out_im;
  } rsp_t;

  // round half up, saturate a Q2.30 sum to Q1.15
  function automatic logic signed [AMP_W-1:0] rnd_sat(input logic signed [33:0] acc);
    logic signed [33:0] t;
    logic signed [18:0] q;
    t = acc + 34'sd16384;
    q = t[33:15];
    if (q > 19'sd32767) return 16'sh7FFF;
    else if (q < -19'sd32768) return 16'sh8000;
    else return q[15:0];
  endfunction

endpackage

// ===== rtl/ppre_if.sv =====
// ----------------------------------------------------------------------------
// ppre_cmd_if / ppre_rsp_if
// Valid/ready channels for commands and responses.
// ----------------------------------------------------------------------------
interface ppre_cmd_if;
  logic          valid;
  logic          ready;
  ppre_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppre_rsp_if;
  logic          valid;
  logic          ready;
  ppre_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pauli_product_rotation_engine.sv =====
// ----------------------------------------------------------------------------
// pauli_product_rotation_engine
// State vector store with write, read and Pauli product rotation passes.
// ----------------------------------------------------------------------------
// channel  dir  payload
// cmd      in   cmd, index, in_re, in_im
// rsp      out  kind, out_re, out_im
// apb      in   flip_mask, phase_mask, cos_q15, sin_q15
//
// Write: accept, then respond. Read: S_RDWAIT and S_RDOUT, then respond;
// the memory read is registered. Rotate: per pair the steps scan, read a,
// read b, multiply, write a, write b; a skipped index takes only the scan.
// With flip_mask zero, each entry skips write b and is updated in place.
// Reset clears control and registers only; the memory holds no reset.
// A stalled response holds the block in its response state.
module pauli_product_rotation_engine #(
  parameter int QUBITS = ppre_pkg::QUBITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  ppre_cmd_if.sink                     cmd,
  ppre_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppre_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int DEPTH = 1 << QUBITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_RDOUT, S_SCAN, S_RA, S_RB, S_MUL, S_WA, S_WB, S_RSP
  } state_t;

  state_t state;
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;
  logic        we;
  logic [QUBITS-1:0] waddr, raddr;
  logic [31:0] wdata;

  logic [ppre_pkg::MASK_W-1:0] flip_mask, phase_mask;
  logic signed [15:0] cos_q15, sin_q15;

  logic [QUBITS-1:0] y, partner;
  logic [QUBITS:0]   ycnt;
  logic [31:0]       amp_a;
  logic [31:0]       res_a, res_b;
  logic signed [31:0] pa_re_c, pa_im_c, pa_re_s, pa_im_s;
  logic signed [31:0] pb_re_c, pb_im_c, pb_re_s, pb_im_s;
  logic [1:0]        k1, k2;
  ppre_pkg::rsp_t    rsp_q;
  logic              rsp_v;

  logic [QUBITS-1:0] xm, zm;
  assign xm = flip_mask[QUBITS-1:0];
  assign zm = phase_mask[QUBITS-1:0];
  assign partner = y ^ xm;

  // apb
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr)
      ppre_pkg::REG_FLIP:  prdata = {22'd0, flip_mask};
      ppre_pkg::REG_PHASE: prdata = {22'd0, phase_mask};
      ppre_pkg::REG_COS:   prdata = {{16{cos_q15[15]}}, cos_q15};
      ppre_pkg::REG_SIN:   prdata = {{16{sin_q15[15]}}, sin_q15};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flip_mask  <= '0;
      phase_mask <= '0;
      cos_q15    <= 16'sh7FFF;
      sin_q15    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ppre_pkg::REG_FLIP:  flip_mask  <= pwdata[9:0];
        ppre_pkg::REG_PHASE: phase_mask <= pwdata[9:0];
        ppre_pkg::REG_COS:   cos_q15    <= pwdata[15:0];
        ppre_pkg::REG_SIN:   sin_q15    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // phases
  logic yz_par, xz_par;
  assign yz_par = ^(y & zm);
  assign xz_par = ^(xm & zm);
  logic [1:0] xz_cnt;
  always_comb begin
    xz_cnt = '0;
    for (int i = 0; i < QUBITS; i++) xz_cnt = xz_cnt + 2'(xm[i] & zm[i]);
  end
  // k2 = 1 + xz + 2*yz ; k1 = k2 + 2*xz
  assign k2 = 2'd1 + xz_cnt + {yz_par, 1'b0};
  assign k1 = k2 + {xz_par, 1'b0};

  // -x of -32768 must stay exact: use 17-bit negation path
  function automatic logic signed [16:0] rpart(input logic [31:0] b, input logic [1:0] k,
                                               input logic sel_im);
    logic signed [16:0] re, im;
    re = {b[15], b[15:0]};
    im = {b[31], b[31:16]};
    case (k)
      2'd0:    return sel_im ? im : re;
      2'd1:    return sel_im ? re : -im;
      2'd2:    return sel_im ? -im : -re;
      default: return sel_im ? -re : im;
    endcase
  endfunction

  logic [1:0] ka, kb;
  assign ka = (xm == '0) ? k2 : k1;
  assign kb = k2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_v <= 1'b0;
      we    <= 1'b0;
    end else begin
      we <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd.valid) begin
          unique case (cmd.data.cmd)
            ppre_pkg::CMD_WRITE: begin
              we    <= 1'b1;
              waddr <= cmd.data.index[QUBITS-1:0];
              wdata <= {cmd.data.in_im, cmd.data.in_re};
              rsp_q <= '{ppre_pkg::KIND_WACK, 16'sd0, 16'sd0};
              rsp_v <= 1'b1;
              state <= S_RSP;
            end
            ppre_pkg::CMD_READ: begin
              raddr <= cmd.data.index[QUBITS-1:0];
              state <= S_RDWAIT;
            end
            ppre_pkg::CMD_ROTATE: begin
              y     <= '0;
              ycnt  <= '0;
              state <= S_SCAN;
            end
            default: ;
          endcase
        end
        S_RDWAIT: state <= S_RDOUT;
        S_RDOUT: begin
          rsp_q <= '{ppre_pkg::KIND_RDAT, rdata[15:0], rdata[31:16]};
          rsp_v <= 1'b1;
          state <= S_RSP;
        end
        S_SCAN: begin
          if (ycnt == (QUBITS+1)'(DEPTH)) begin
            rsp_q <= '{ppre_pkg::KIND_DONE, 16'sd0, 16'sd0};
            rsp_v <= 1'b1;
            state <= S_RSP;
          end else if (xm == '0 || y < partner) begin
            raddr <= y;
            state <= S_RA;
          end else begin
            y    <= y + 1'b1;
            ycnt <= ycnt + 1'b1;
          end
        end
        S_RA: begin
          raddr <= partner;
          state <= S_RB;
        end
        S_RB: begin
          amp_a <= rdata;
          state <= S_MUL;
        end
        S_MUL: begin
          pa_re_c <= $signed(amp_a[15:0]) * cos_q15;
          pa_im_c <= $signed(amp_a[31:16]) * cos_q15;
          pb_re_c <= $signed(rdata[15:0]) * cos_q15;
          pb_im_c <= $signed(rdata[31:16]) * cos_q15;
          pa_re_s <= 32'(rpart((xm == '0) ? amp_a : rdata, ka, 1'b0) * sin_q15);
          pa_im_s <= 32'(rpart((xm == '0) ? amp_a : rdata, ka, 1'b1) * sin_q15);
          pb_re_s <= 32'(rpart(amp_a, kb, 1'b0) * sin_q15);
          pb_im_s <= 32'(rpart(amp_a, kb, 1'b1) * sin_q15);
          state   <= S_WA;
        end
        S_WA: begin
          we    <= 1'b1;
          waddr <= y;
          wdata <= res_a;
          if (xm == '0) begin
            y     <= y + 1'b1;
            ycnt  <= ycnt + 1'b1;
            state <= S_SCAN;
          end else begin
            state <= S_WB;
          end
        end
        S_WB: begin
          we    <= 1'b1;
          waddr <= partner;
          wdata <= res_b;
          y     <= y + 1'b1;
          ycnt  <= ycnt + 1'b1;
          state <= S_SCAN;
        end
        S_RSP: if (rsp.ready) begin
          rsp_v <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_a = {ppre_pkg::rnd_sat(34'(pa_im_c) + 34'(pa_im_s)),
                  ppre_pkg::rnd_sat(34'(pa_re_c) + 34'(pa_re_s))};
  assign res_b = {ppre_pkg::rnd_sat(34'(pb_im_c) + 34'(pb_im_s)),
                  ppre_pkg::rnd_sat(34'(pb_re_c) + 34'(pb_re_s))};

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = rsp_v;
  assign rsp.data  = rsp_q;

`ifndef SYNTHESIS
  a_rsp_only_in_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_v |-> state == S_RSP) else $error("response valid outside response state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !rsp_v) else $error("ready while response pending");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> ycnt <= (QUBITS+1)'(DEPTH)) else $error("scan overrun");
`endif

endmodule

// ===== tb/ppre_state_vector_checker.sv =====
// ----------------------------------------------------------------------------
// ppre_state_vector_checker
// Watches the command, response and register ports of the rotation engine,
// keeps its own copy of the state vector and registers, predicts every
// response and compares it field by field with what the engine returns.
// ----------------------------------------------------------------------------
module ppre_state_vector_checker (
  input  logic                          clk,
  input  logic                          rst,
  ppre_cmd_if                           cmd,
  ppre_rsp_if                           rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppre_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 1 << ppre_pkg::QUBITS_DEF;

  logic [31:0]                    amp_mem [DIM];
  logic [ppre_pkg::MASK_W-1:0]    flip_x;
  logic [ppre_pkg::MASK_W-1:0]    phase_z;
  int                             cos_c;
  int                             sin_s;
  ppre_pkg::rsp_t                 expected_rsp [$];

  function automatic logic [15:0] sat_q15(longint acc);
    longint q;
    q = (acc + 16384) >>> 15;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // a*c + b*s*i^k per component
  function automatic logic [31:0] mix_pair(logic [31:0] a, logic [31:0] b, logic [1:0] k);
    int are, aim, bre, bim, tre, tim;
    longint sre, sim;
    are = $signed(a[15:0]);
    aim = $signed(a[31:16]);
    bre = $signed(b[15:0]);
    bim = $signed(b[31:16]);
    case (k)
      2'd0: begin tre = bre;  tim = bim;  end
      2'd1: begin tre = -bim; tim = bre;  end
      2'd2: begin tre = -bre; tim = -bim; end
      default: begin tre = bim; tim = -bre; end
    endcase
    sre = longint'(are) * cos_c + longint'(tre) * sin_s;
    sim = longint'(aim) * cos_c + longint'(tim) * sin_s;
    return {sat_q15(sim), sat_q15(sre)};
  endfunction

  function automatic void rotate_vector();
    int xz, yz;
    logic [1:0] k1, k2;
    logic [ppre_pkg::MASK_W-1:0] partner;
    logic [31:0] a, b;
    xz = $countones(flip_x & phase_z);
    for (int y = 0; y < DIM; y++) begin
      yz = $countones(ppre_pkg::MASK_W'(y) & phase_z);
      k1 = 2'((1 + xz + 2 * (yz + xz)) & 3);
      k2 = 2'((1 + xz + 2 * yz) & 3);
      partner = ppre_pkg::MASK_W'(y) ^ flip_x;
      if (flip_x == '0) begin
        a = amp_mem[y];
        amp_mem[y] = mix_pair(a, a, k2);
      end else if (y < int'(partner)) begin
        a = amp_mem[y];
        b = amp_mem[partner];
        amp_mem[y] = mix_pair(a, b, k1);
        amp_mem[partner] = mix_pair(b, a, k2);
      end
    end
  endfunction

  always @(posedge clk) begin
    ppre_pkg::rsp_t e, want;
    ppre_pkg::cmd_t c;
    if (rst) begin
      flip_x = '0;
      phase_z = '0;
      cos_c = 32767;
      sin_s = 0;
      expected_rsp.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ppre_pkg::REG_FLIP:  flip_x = pwdata[ppre_pkg::MASK_W-1:0];
          ppre_pkg::REG_PHASE: phase_z = pwdata[ppre_pkg::MASK_W-1:0];
          ppre_pkg::REG_COS:   cos_c = $signed(pwdata[15:0]);
          ppre_pkg::REG_SIN:   sin_s = $signed(pwdata[15:0]);
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected response kind=%0d re=%0d im=%0d",
                     rsp.data.kind, rsp.data.out_re, rsp.data.out_im);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.data.kind !== want.kind || rsp.data.out_re !== want.out_re ||
              rsp.data.out_im !== want.out_im) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"response mismatch: expected kind=%0d re=%0d im=%0d, ",
                        "got kind=%0d re=%0d im=%0d"},
                       want.kind, want.out_re, want.out_im,
                       rsp.data.kind, rsp.data.out_re, rsp.data.out_im);
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        c = cmd.data;
        e = '0;
        case (c.cmd)
          ppre_pkg::CMD_WRITE: begin
            amp_mem[c.index] = {c.in_im, c.in_re};
            e.kind = ppre_pkg::KIND_WACK;
            expected_rsp.push_back(e);
          end
          ppre_pkg::CMD_READ: begin
            e.kind = ppre_pkg::KIND_RDAT;
            e.out_re = amp_mem[c.index][15:0];
            e.out_im = amp_mem[c.index][31:16];
            expected_rsp.push_back(e);
          end
          ppre_pkg::CMD_ROTATE: begin
            rotate_vector();
            e.kind = ppre_pkg::KIND_DONE;
            expected_rsp.push_back(e);
          end
          default: ;
        endcase
      end
    end
    pending = expected_rsp.size();
  end

endmodule

// ===== tb/pauli_product_rotation_engine_test.sv =====
// ----------------------------------------------------------------------------
// pauli_product_rotation_engine_test
// Fills the state vector, runs directed extremes and then random writes,
// reads and rotation passes under several register settings, with random
// stalls on both channels. The checker predicts and compares every response.
// ----------------------------------------------------------------------------
module pauli_product_rotation_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM   = 1 << ppre_pkg::QUBITS_DEF;
  localparam int LIMIT = 1_500_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite;
  logic [ppre_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic cmd_ready_seen;
  logic quiet;
  int fail_count, pending;
  int cycles = 0;
  int rsp_stall = 0;
  int n_items, n_rot, n_settings;

  ppre_cmd_if cmd_ch ();
  ppre_rsp_if rsp_ch ();

  pauli_product_rotation_engine DUT (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ppre_state_vector_checker checker_i (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) cmd_ready_seen = cmd_ch.ready;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("pauli_product_rotation_engine test failed");
      $finish;
    end
  end

  // response side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 0;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall <= rsp_stall - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rsp_stall <= $urandom_range(0, 9);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic logic [15:0] pick_amp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic [ppre_pkg::CMD_W-1:0] op, logic [ppre_pkg::IDX_W-1:0] idx,
                      logic [15:0] re, logic [15:0] im);
    ppre_pkg::cmd_t c;
    c.cmd = op;
    c.index = idx;
    c.in_re = re;
    c.in_im = im;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    do @(posedge clk); while (!cmd_ready_seen);
    if (op != ppre_pkg::CMD_RSVD) n_items++;
    if (op == ppre_pkg::CMD_ROTATE) n_rot++;
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(logic [ppre_pkg::ADDR_W-1:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [9:0] x, logic [9:0] z, logic [15:0] c, logic [15:0] s);
    drain();
    apb_write(ppre_pkg::REG_FLIP, 32'(x));
    apb_write(ppre_pkg::REG_PHASE, 32'(z));
    apb_write(ppre_pkg::REG_COS, {16'($urandom), c});
    apb_write(ppre_pkg::REG_SIN, {16'($urandom), s});
    n_settings++;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) send(ppre_pkg::CMD_WRITE, 10'($urandom), pick_amp(), pick_amp());
    else if (r < 88)
      send(ppre_pkg::CMD_READ, 10'($urandom), 16'($urandom), 16'($urandom));
    else if (r < 95)
      send(ppre_pkg::CMD_ROTATE, 10'($urandom), 16'($urandom), 16'($urandom));
    else send(ppre_pkg::CMD_RSVD, 10'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int target;
    n_items = 0;
    n_rot = 0;
    n_settings = 0;
    quiet = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every entry written before any rotation or read
    for (int i = 0; i < DIM; i++)
      send(ppre_pkg::CMD_WRITE, 10'(i), pick_amp(), pick_amp());

    // directed extremes
    send(ppre_pkg::CMD_WRITE, 10'd0, 16'h8000, 16'h8000);
    send(ppre_pkg::CMD_WRITE, 10'd1023, 16'h7FFF, 16'h7FFF);
    send(ppre_pkg::CMD_WRITE, 10'd512, 16'h7FFF, 16'h8000);
    send(ppre_pkg::CMD_READ, 10'd0, 16'h0, 16'h0);
    send(ppre_pkg::CMD_READ, 10'd1023, 16'hFFFF, 16'hFFFF);
    send(ppre_pkg::CMD_READ, 10'd512, 16'h0, 16'h0);
    send(ppre_pkg::CMD_RSVD, 10'd5, 16'h1234, 16'h5678);
    send(ppre_pkg::CMD_READ, 10'd5, 16'h0, 16'h0);
    send(ppre_pkg::CMD_ROTATE, 10'd0, 16'h0, 16'h0);
    send(ppre_pkg::CMD_READ, 10'd0, 16'h0, 16'h0);
    set_regs(10'd1023, 10'd1023, 16'h8000, 16'h8000);
    send(ppre_pkg::CMD_ROTATE, 10'd0, 16'h0, 16'h0);
    send(ppre_pkg::CMD_READ, 10'd0, 16'h0, 16'h0);
    send(ppre_pkg::CMD_READ, 10'd1023, 16'h0, 16'h0);
    set_regs(10'd0, 10'd1023, 16'h7FFF, 16'h7FFF);
    send(ppre_pkg::CMD_ROTATE, 10'd0, 16'h0, 16'h0);
    send(ppre_pkg::CMD_READ, 10'd1023, 16'h0, 16'h0);
    set_regs(10'd1, 10'd0, 16'h0, 16'h8000);
    send(ppre_pkg::CMD_ROTATE, 10'd0, 16'h0, 16'h0);
    send(ppre_pkg::CMD_READ, 10'd1, 16'h0, 16'h0);

    // random phases under varied settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom));
        1: set_regs(10'd0, 10'($urandom), 16'($urandom), 16'($urandom));
        2: set_regs(10'd1 << $urandom_range(0, 9), 10'($urandom), 16'd23170, 16'd23170);
        3: set_regs(10'($urandom), 10'd0, 16'h0, 16'h7FFF);
        4: set_regs(10'd512, 10'd513, 16'h8000, 16'h7FFF);
        default: set_regs(10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom));
      endcase
      quiet = (p == 5);
      target = n_items + 95;
      while (n_items < target) random_item();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("ran %0d commands, %0d of them rotation passes, under %0d register settings",
             n_items, n_rot, n_settings);
    if (fail_count == 0) begin
      $display("pauli_product_rotation_engine test passed");
    end else begin
      $display("pauli_product_rotation_engine test failed");
    end
    $finish;
  end

endmodule
